// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the profile generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only outside reset.
`define PLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked only outside reset.
`define PLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PLP_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/plp_pkg.sv
// Types, constants and register codes of the piecewise-linear profile generator.
`default_nettype none

package plp_pkg;

  localparam int MAX_POINTS_DEF = 16;

  localparam int TIME_W        = 32;
  localparam int VALUE_W       = 32;
  localparam int INDEX_W       = 4;
  localparam int POINT_COUNT_W = 5;
  localparam int END_TIME_W    = 31;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME    = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_COMPARE,
    ST_MULT,
    ST_DIVIDE,
    ST_OUT_INTERP,
    ST_OUT_LAST
  } state_t;

  typedef enum logic [1:0] {
    SEL_FLAT,
    SEL_INTERP,
    SEL_LAST
  } emit_sel_t;

  typedef struct packed {
    logic      load_query;
    logic      cap_last;
    logic      seg_setup;
    logic      mul_load;
    logic      div_step;
    logic      emit;
    emit_sel_t emit_sel;
  } cmd_t;

  typedef struct packed {
    logic past_end;
    logic in_seg;
    logic flat;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/piecewise_linear_profile.sv
// Piecewise-linear setpoint profile generator, top level.
//
// Input channel (in_*): one word per item. op 0 stores a breakpoint (time,
// value) at in_point_index and returns nothing; op 1 queries the profile at
// in_sample_time and returns one word on the result channel (out_*).
// A write does not raise in_stall. A query keeps in_stall high for a segment
// scan that examines at most MAX_POINTS-1 segments, plus multiply, 32-step
// divide and hand-off when it interpolates. A time past end_time skips the
// scan; a flat segment skips multiply and divide.
// The scan reads both table memories through two registered read ports, one
// segment per READ and COMPARE state pair, and the divider yields one
// quotient bit a cycle. The result word is valid in the same cycle in which
// in_stall drops; the next item is taken from that cycle on. The output
// register holds a result while out_stall is high; the block takes the next
// item meanwhile, and a later query waits for the register. cfg_we writes
// point_count (index 0) or end_time (index 1); the user must write them only
// while idle, which the block itself does not enforce. Reset (rst_n low,
// synchronous) clears the sequencer and the result valid, sets point_count
// to 1 and end_time to 0; the table contents are undefined until written.
`default_nettype none

module piecewise_linear_profile #(
  parameter int MAX_POINTS = plp_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [plp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [plp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_op,
  input  wire logic [plp_pkg::INDEX_W-1:0]          in_point_index,
  input  wire logic signed [plp_pkg::TIME_W-1:0]    in_sample_time,
  input  wire logic signed [plp_pkg::VALUE_W-1:0]   in_point_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [plp_pkg::VALUE_W-1:0]        out_profile_value,
  output logic                                      out_held_last
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  logic [plp_pkg::POINT_COUNT_W-1:0] point_count_r;
  logic [plp_pkg::END_TIME_W-1:0]    end_time_r;

  logic             in_fire, busy;
  plp_pkg::cmd_t    cmd;
  plp_pkg::sts_t    sts;
  logic [IDX_W-1:0] rd_addr_a, rd_addr_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= plp_pkg::POINT_COUNT_W'(1);
      end_time_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        plp_pkg::REG_POINT_COUNT: point_count_r <= cfg_data[plp_pkg::POINT_COUNT_W-1:0];
        plp_pkg::REG_END_TIME:    end_time_r    <= cfg_data[plp_pkg::END_TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  plp_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .query_fire  (in_fire && (in_op == plp_pkg::OP_QUERY)),
    .point_count (point_count_r),
    .sts         (sts),
    .cmd         (cmd),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .busy        (busy)
  );

  plp_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .rd_addr_a         (rd_addr_a),
    .rd_addr_b         (rd_addr_b),
    .wr_en             (in_fire && (in_op == plp_pkg::OP_WRITE)),
    .wr_idx            (in_point_index),
    .in_sample_time    (in_sample_time),
    .in_point_value    (in_point_value),
    .end_time          (end_time_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_profile_value (out_profile_value),
    .out_held_last     (out_held_last)
  );

endmodule

`default_nettype wire

// File: rtl/core/plp_datapath.sv
// Breakpoint tables, segment arithmetic, divider and result register.
`default_nettype none

module plp_datapath #(
  parameter int MAX_POINTS = plp_pkg::MAX_POINTS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire plp_pkg::cmd_t                        cmd,
  output plp_pkg::sts_t                             sts,
  input  wire logic [IDX_W-1:0]                     rd_addr_a,
  input  wire logic [IDX_W-1:0]                     rd_addr_b,
  input  wire logic                                 wr_en,
  input  wire logic [plp_pkg::INDEX_W-1:0]          wr_idx,
  input  wire logic signed [plp_pkg::TIME_W-1:0]    in_sample_time,
  input  wire logic signed [plp_pkg::VALUE_W-1:0]   in_point_value,
  input  wire logic [plp_pkg::END_TIME_W-1:0]       end_time,
  input  wire logic                                 out_stall,
  output logic                                      out_valid,
  output logic signed [plp_pkg::VALUE_W-1:0]        out_profile_value,
  output logic                                      out_held_last
);

  logic [plp_pkg::TIME_W-1:0]  time_mem  [MAX_POINTS];
  logic [plp_pkg::VALUE_W-1:0] value_mem [MAX_POINTS];

  logic signed [plp_pkg::TIME_W-1:0]  rd_ta_r, rd_tb_r;
  logic signed [plp_pkg::VALUE_W-1:0] rd_va_r, rd_vb_r;
  logic signed [plp_pkg::TIME_W-1:0]  tq_r;
  logic [plp_pkg::VALUE_W-1:0]        last_r;
  logic [plp_pkg::VALUE_W-1:0]        v0_r;
  logic [31:0]                        mag_r, num_r, den_r;
  logic                               neg_r;
  logic [31:0]                        rem_r, quo_r;
  logic [31:0]                        rem_nxt, quo_nxt;
  logic                               out_valid_r;
  logic [plp_pkg::VALUE_W-1:0]        out_value_r, out_value_nxt;
  logic                               out_held_r;

  logic        idx_ok;
  logic [32:0] dv, dv_abs;
  logic [63:0] prod;
  logic [32:0] trial, diff;
  logic        ge;

  // Slots beyond the table are dropped.
  assign idx_ok = {28'd0, wr_idx} < 32'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (wr_en && idx_ok) begin
      time_mem[IDX_W'(wr_idx)]  <= in_sample_time;
      value_mem[IDX_W'(wr_idx)] <= in_point_value;
    end
    rd_ta_r <= time_mem[rd_addr_a];
    rd_tb_r <= time_mem[rd_addr_b];
    rd_va_r <= value_mem[rd_addr_a];
    rd_vb_r <= value_mem[rd_addr_b];
  end

  assign dv     = {rd_vb_r[31], rd_vb_r} - {rd_va_r[31], rd_va_r};
  assign dv_abs = dv[32] ? (~dv + 33'd1) : dv;
  assign prod   = mag_r * num_r;

  // One quotient bit per step; the high half of the product stays below the divisor.
  assign trial   = {rem_r, quo_r[31]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = (trial >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[31:0] : trial[31:0];
  assign quo_nxt = {quo_r[30:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      // clamp negative times to zero
      tq_r <= in_sample_time[31] ? '0 : in_sample_time;
    end
    if (cmd.cap_last) begin
      last_r <= rd_va_r;
    end
    if (cmd.seg_setup) begin
      neg_r <= dv[32];
      mag_r <= dv_abs[31:0];
      num_r <= tq_r - rd_ta_r;
      den_r <= rd_tb_r - rd_ta_r;
      v0_r  <= rd_va_r;
    end
    if (cmd.mul_load) begin
      rem_r <= prod[63:32];
      quo_r <= prod[31:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      plp_pkg::SEL_FLAT:   out_value_nxt = rd_va_r;
      plp_pkg::SEL_INTERP: out_value_nxt = neg_r ? (v0_r - quo_r) : (v0_r + quo_r);
      plp_pkg::SEL_LAST:   out_value_nxt = last_r;
      default:             out_value_nxt = last_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= out_value_nxt;
      out_held_r  <= (cmd.emit_sel == plp_pkg::SEL_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.past_end = $unsigned(tq_r) > {1'b0, end_time};
  assign sts.in_seg   = (tq_r >= rd_ta_r) && (tq_r <= rd_tb_r);
  assign sts.flat     = (rd_ta_r == rd_tb_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_profile_value = out_value_r;
  assign out_held_last     = out_held_r;

endmodule

`default_nettype wire

// File: rtl/core/plp_ctrl.sv
// Query sequencer: segment scan, multiply and divide steps, result hand-off.
`default_nettype none

module plp_ctrl #(
  parameter int MAX_POINTS = plp_pkg::MAX_POINTS_DEF,
  localparam int IDX_W = $clog2(MAX_POINTS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                query_fire,
  input  wire logic [plp_pkg::POINT_COUNT_W-1:0]   point_count,
  input  wire plp_pkg::sts_t                       sts,
  output plp_pkg::cmd_t                            cmd,
  output logic [IDX_W-1:0]                         rd_addr_a,
  output logic [IDX_W-1:0]                         rd_addr_b,
  output logic                                     busy
);

  localparam int CW = (IDX_W + 1 > plp_pkg::POINT_COUNT_W) ? IDX_W + 1
                                                             : plp_pkg::POINT_COUNT_W;

  plp_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]              seg_r, seg_nxt;
  logic [plp_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic [CW-1:0]    pc_ext, max_ext, last_c;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W:0]   seg_inc;
  logic             last_seg;

  // Clamp the count to 1..MAX_POINTS and keep the index of the last point.
  assign pc_ext   = CW'(point_count);
  assign max_ext  = CW'(MAX_POINTS);
  assign last_c   = (pc_ext == '0) ? '0 :
                    (pc_ext > max_ext) ? (max_ext - CW'(1)) : (pc_ext - CW'(1));
  assign last_idx = last_c[IDX_W-1:0];

  assign seg_inc  = {1'b0, seg_r} + {{IDX_W{1'b0}}, 1'b1};
  assign last_seg = (seg_inc == {1'b0, last_idx});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= plp_pkg::ST_IDLE;
      seg_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      seg_r     <= seg_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    seg_nxt     = seg_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    cmd.emit_sel = plp_pkg::SEL_LAST;

    case (state_r)
      plp_pkg::ST_IDLE: begin
        cmd.load_query = query_fire;
        if (query_fire) begin
          state_nxt = plp_pkg::ST_CHECK;
        end
      end
      plp_pkg::ST_CHECK: begin
        cmd.cap_last = 1'b1;
        seg_nxt      = '0;
        if (sts.past_end || last_idx == '0) begin
          state_nxt = plp_pkg::ST_OUT_LAST;
        end else begin
          state_nxt = plp_pkg::ST_READ;
        end
      end
      plp_pkg::ST_READ: begin
        state_nxt = plp_pkg::ST_COMPARE;
      end
      plp_pkg::ST_COMPARE: begin
        if (sts.in_seg) begin
          if (sts.flat) begin
            // hold here until the result register frees up
            if (sts.out_free) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = plp_pkg::SEL_FLAT;
              state_nxt    = plp_pkg::ST_IDLE;
            end
          end else begin
            cmd.seg_setup = 1'b1;
            state_nxt     = plp_pkg::ST_MULT;
          end
        end else if (last_seg) begin
          state_nxt = plp_pkg::ST_OUT_LAST;
        end else begin
          seg_nxt   = seg_inc[IDX_W-1:0];
          state_nxt = plp_pkg::ST_READ;
        end
      end
      plp_pkg::ST_MULT: begin
        cmd.mul_load = 1'b1;
        div_cnt_nxt  = plp_pkg::DIV_CNT_W'(plp_pkg::DIV_STEPS - 1);
        state_nxt    = plp_pkg::ST_DIVIDE;
      end
      plp_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = plp_pkg::ST_OUT_INTERP;
        end else begin
          div_cnt_nxt = div_cnt_r - plp_pkg::DIV_CNT_W'(1);
        end
      end
      plp_pkg::ST_OUT_INTERP: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = plp_pkg::SEL_INTERP;
          state_nxt    = plp_pkg::ST_IDLE;
        end
      end
      plp_pkg::ST_OUT_LAST: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = plp_pkg::SEL_LAST;
          state_nxt    = plp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = plp_pkg::ST_IDLE;
      end
    endcase
  end

  // Port A sits on the last point while idle so its value is ready at query start.
  assign rd_addr_a = (state_r == plp_pkg::ST_IDLE || state_r == plp_pkg::ST_CHECK)
                     ? last_idx : seg_r;
  assign rd_addr_b = seg_inc[IDX_W-1:0];
  assign busy      = (state_r != plp_pkg::ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/plp_checker.sv
// Port-level checks of the profile generator, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module plp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_op,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_profile_value,
  input wire logic        out_held_last
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled result word holds
  `PLP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_profile_value) && $stable(out_held_last), "stalled result word changed")

  // a new result never appears right after an item is taken
  `PLP_ASSERT_NXT(a_no_result_on_accept, in_acc, !$rose(out_valid), "result appeared right after an accepted word")

  // an accepted query stalls the input right after it is taken
  `PLP_ASSERT_NXT(a_query_busy, in_acc && in_op, in_stall, "input not stalled after a query")

  // reset leaves no result pending and the input open
  `PLP_ASSERT_NXT_RST(a_reset_state, !rst_n, !out_valid && !in_stall, "bad state after reset")

endmodule

bind piecewise_linear_profile plp_checker u_plp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_op             (in_op),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_profile_value (out_profile_value),
  .out_held_last     (out_held_last)
);

`default_nettype wire
